// File: src/asdl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the averaged sensor distance linearizer.
package asdl_pkg;

    localparam int ADC_IN_W   = 10;
    localparam int ADC_MAX_W  = 16;
    localparam int COEF_W     = 32;
    localparam int NUM_COEFS  = 7;
    localparam int K_W        = $clog2(NUM_COEFS);
    localparam int DIST_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int V_W        = 18;
    localparam int FRAC_W     = 16;
    localparam int OUT_SHIFT  = 8;

    // 3.3 in unsigned Q2.16, rounded to nearest
    localparam logic [V_W-1:0] VREF_Q16 = V_W'(216269);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_POW6  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_POW5  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = CFG_IDX_W'(7);

    localparam logic [COEF_W-1:0] COEF_SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic [NUM_COEFS-1:0][COEF_W-1:0] coef;
        logic [DIST_W-1:0]                min_dist;
    } t_lin_cfg;

    // element 0 is the sixth-power coefficient
    localparam logic [NUM_COEFS-1:0][COEF_W-1:0] COEF_RESET = {
        COEF_W'(7911506),
        COEF_W'(-17832346),
        COEF_W'(21679309),
        COEF_W'(-14775747),
        COEF_W'(5569446),
        COEF_W'(-1074528),
        COEF_W'(81933)
    };
    localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(1792);

endpackage

// File: src/averaged_sensor_distance_linearizer_core.sv
`timescale 1ns / 1ps
// Top level of the averaged sensor distance linearizer.
//
//  channel   handshake                    payload
//  samples   push / full                  i_adc_sample
//  results   empty / pop                  o_distance_cm
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Front end per sample: store read, then sum update and write-back.
// Back end per result: mean and voltage on the shared multiplier,
// then six Horner steps of multiply and add; this multiplier loop sets the rate.
// The first DEPTH samples give no result. Reset is synchronous; the store needs no clear.
// Two-entry queues sit between front and back and ahead of the result port.
module averaged_sensor_distance_linearizer_core #(
    parameter int DEPTH    = 10,
    parameter int ADC_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [asdl_pkg::ADC_IN_W-1:0]   i_adc_sample,
    output logic                            empty,
    input  logic                            pop,
    output logic [asdl_pkg::DIST_W-1:0]     o_distance_cm,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [asdl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [asdl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = ADC_BITS + $clog2(DEPTH);

    asdl_pkg::t_lin_cfg              r_cfg;
    logic                            w_sum_push;
    logic                            w_sum_full;
    logic [SUM_W-1:0]                w_sum_in;
    logic                            w_sum_pop;
    logic                            w_sum_empty;
    logic [SUM_W-1:0]                w_sum_out;
    logic                            w_res_push;
    logic                            w_res_full;
    logic [asdl_pkg::DIST_W-1:0]     w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef     <= asdl_pkg::COEF_RESET;
            r_cfg.min_dist <= asdl_pkg::MIN_DIST_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index <= asdl_pkg::REG_COEF_CONST) begin
                r_cfg.coef[i_cfg_index[asdl_pkg::K_W-1:0]] <=
                    i_cfg_data[asdl_pkg::COEF_W-1:0];
            end else if (i_cfg_index == asdl_pkg::REG_MIN_DIST) begin
                r_cfg.min_dist <= i_cfg_data[asdl_pkg::DIST_W-1:0];
            end
        end
    end

    asdl_front #(
        .DEPTH    (DEPTH),
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_adc_sample (i_adc_sample),
        .o_sum_push   (w_sum_push),
        .i_sum_full   (w_sum_full),
        .o_sum        (w_sum_in)
    );

    asdl_fifo #(
        .WIDTH (SUM_W)
    ) u_sum_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_sum_push),
        .o_full  (w_sum_full),
        .i_data  (w_sum_in),
        .i_pop   (w_sum_pop),
        .o_empty (w_sum_empty),
        .o_data  (w_sum_out)
    );

    asdl_back #(
        .DEPTH    (DEPTH),
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_sum_empty (w_sum_empty),
        .o_sum_pop   (w_sum_pop),
        .i_sum       (w_sum_out),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full),
        .o_res       (w_res)
    );

    asdl_fifo #(
        .WIDTH (asdl_pkg::DIST_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .o_full  (w_res_full),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_distance_cm)
    );

`ifndef SYNTHESIS
    a_sum_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sum_push && w_sum_full))
        else $error("sum transfer into a full queue");

    a_res_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_res_full))
        else $error("result transfer into a full queue");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum_pop |-> !w_sum_empty)
        else $error("back end took a sum from an empty queue");
`endif

endmodule

// File: src/asdl_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue used between the front end, the back end and the result port.
module asdl_fifo #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: src/asdl_front.sv
`timescale 1ns / 1ps
// Front end: sample store, running sum and warm-up tracking.
module asdl_front #(
    parameter int DEPTH    = 10,
    parameter int ADC_BITS = 10,
    localparam int IDX_W   = $clog2(DEPTH),
    localparam int SUM_W   = ADC_BITS + $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [asdl_pkg::ADC_IN_W-1:0] i_adc_sample,
    output logic                         o_sum_push,
    input  logic                         i_sum_full,
    output logic [SUM_W-1:0]             o_sum
);

    typedef enum logic {
        F_IDLE,
        F_UPD
    } t_fstate;

    t_fstate                       r_state;
    logic [ADC_BITS-1:0]           r_mem [DEPTH];
    logic [ADC_BITS-1:0]           r_old;
    logic [ADC_BITS-1:0]           r_sample;
    logic [IDX_W-1:0]              r_idx;
    logic [SUM_W-1:0]              r_sum;
    logic                          r_warm;
    logic [asdl_pkg::ADC_MAX_W-1:0] w_wide;
    logic [ADC_BITS-1:0]           w_sample;
    logic                          w_commit;
    logic                          w_wrap;
    logic [SUM_W-1:0]              n_sum;

    assign w_wide   = asdl_pkg::ADC_MAX_W'(i_adc_sample);
    assign w_sample = w_wide[ADC_BITS-1:0];
    assign w_wrap   = (r_idx == IDX_W'(DEPTH - 1));
    assign w_commit = (r_state == F_UPD) && (!r_warm || !i_sum_full);
    assign n_sum    = r_warm ? (r_sum - SUM_W'(r_old) + SUM_W'(r_sample))
                             : (r_sum + SUM_W'(r_sample));

    assign o_full     = (r_state != F_IDLE);
    assign o_sum_push = (r_state == F_UPD) && r_warm && !i_sum_full;
    assign o_sum      = n_sum;

    // oldest entry is read every cycle; it is settled by the update cycle
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_mem[r_idx] <= r_sample;
        end
        r_old <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_idx   <= '0;
            r_sum   <= '0;
            r_warm  <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_sample <= w_sample;
                        r_state  <= F_UPD;
                    end
                end
                F_UPD: begin
                    if (w_commit) begin
                        r_sum   <= n_sum;
                        r_idx   <= w_wrap ? '0 : r_idx + IDX_W'(1);
                        if (w_wrap) begin
                            r_warm <= 1'b1;
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/asdl_back.sv
`timescale 1ns / 1ps
// Back end: mean, voltage scaling and Horner evaluation on one shared multiplier.
module asdl_back #(
    parameter int DEPTH    = 10,
    parameter int ADC_BITS = 10,
    localparam int SUM_W   = ADC_BITS + $clog2(DEPTH),
    localparam int REM_W   = $clog2(DEPTH) + 1,
    localparam int B_W     = (SUM_W > asdl_pkg::V_W) ? SUM_W : asdl_pkg::V_W,
    localparam int P_W     = asdl_pkg::COEF_W + B_W + 1,
    localparam int S_W     = P_W - asdl_pkg::FRAC_W,
    localparam int E_W     = S_W + 1,
    localparam int D_W     = asdl_pkg::COEF_W - asdl_pkg::OUT_SHIFT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  asdl_pkg::t_lin_cfg          i_cfg,
    input  logic                        i_sum_empty,
    output logic                        o_sum_pop,
    input  logic [SUM_W-1:0]            i_sum,
    output logic                        o_res_push,
    input  logic                        i_res_full,
    output logic [asdl_pkg::DIST_W-1:0] o_res
);

    // floor(2^SUM_W / DEPTH); the estimate is low by at most one
    localparam logic [B_W-1:0] RECIP = B_W'((64'd1 << SUM_W) / DEPTH);

    typedef enum logic [2:0] {
        B_IDLE,
        B_MEAN_MUL,
        B_MEAN_FIX,
        B_VOLT,
        B_VSET,
        B_HMUL,
        B_HADD,
        B_OUT
    } t_bstate;

    t_bstate                            r_state;
    logic [SUM_W-1:0]                   r_sum;
    logic signed [P_W-1:0]              r_prod;
    logic [ADC_BITS-1:0]                r_mean;
    logic [REM_W-1:0]                   r_rem;
    logic [asdl_pkg::V_W-1:0]           r_v;
    logic signed [asdl_pkg::COEF_W-1:0] r_acc;
    logic [asdl_pkg::K_W-1:0]           r_k;

    logic signed [asdl_pkg::COEF_W-1:0] w_mul_a;
    logic [B_W-1:0]                     w_mul_b;
    logic signed [P_W-1:0]              w_prod;
    logic [ADC_BITS-1:0]                w_q0;
    logic [SUM_W-1:0]                   w_qd;
    logic [SUM_W-1:0]                   w_rem_full;
    logic [ADC_BITS-1:0]                w_mean_c;
    logic signed [S_W-1:0]              w_shift;
    logic signed [asdl_pkg::COEF_W-1:0] w_coef_k;
    logic signed [E_W-1:0]              w_hsum;
    logic [E_W-asdl_pkg::COEF_W:0]      w_hi;
    logic [asdl_pkg::COEF_W-1:0]        w_hsat;
    logic signed [D_W-1:0]              w_dist;
    logic                               w_below;
    logic                               w_above;

    always_comb begin
        unique case (r_state)
            B_MEAN_MUL: begin
                w_mul_a = $signed(asdl_pkg::COEF_W'(r_sum));
                w_mul_b = RECIP;
            end
            B_VOLT: begin
                w_mul_a = $signed(asdl_pkg::COEF_W'(w_mean_c));
                w_mul_b = B_W'(asdl_pkg::VREF_Q16);
            end
            default: begin
                w_mul_a = r_acc;
                w_mul_b = B_W'(r_v);
            end
        endcase
    end

    assign w_prod = w_mul_a * $signed({1'b0, w_mul_b});

    assign w_q0       = r_prod[SUM_W +: ADC_BITS];
    assign w_qd       = SUM_W'(w_q0) * SUM_W'(DEPTH);
    assign w_rem_full = r_sum - w_qd;
    assign w_mean_c   = (r_rem >= REM_W'(DEPTH)) ? r_mean + ADC_BITS'(1) : r_mean;

    assign w_shift  = r_prod[P_W-1:asdl_pkg::FRAC_W];
    assign w_coef_k = $signed(i_cfg.coef[r_k]);
    assign w_hsum   = w_shift + w_coef_k;
    assign w_hi     = w_hsum[E_W-1:asdl_pkg::COEF_W-1];
    assign w_hsat   = ((&w_hi) || !(|w_hi)) ? w_hsum[asdl_pkg::COEF_W-1:0]
                    : (w_hsum[E_W-1] ? asdl_pkg::COEF_SAT_MIN : asdl_pkg::COEF_SAT_MAX);

    assign w_dist  = r_acc[asdl_pkg::COEF_W-1:asdl_pkg::OUT_SHIFT];
    assign w_below = w_dist < $signed({1'b0, i_cfg.min_dist});
    assign w_above = !w_dist[D_W-1] && (|w_dist[D_W-2:asdl_pkg::DIST_W]);

    always_comb begin
        if (w_below) begin
            o_res = i_cfg.min_dist;
        end else if (w_above) begin
            o_res = '1;
        end else begin
            o_res = w_dist[asdl_pkg::DIST_W-1:0];
        end
    end

    assign o_sum_pop  = (r_state == B_IDLE) && !i_sum_empty;
    assign o_res_push = (r_state == B_OUT) && !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_sum_empty) begin
                        r_sum   <= i_sum;
                        r_state <= B_MEAN_MUL;
                    end
                end
                B_MEAN_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= B_MEAN_FIX;
                end
                B_MEAN_FIX: begin
                    r_mean  <= w_q0;
                    r_rem   <= w_rem_full[REM_W-1:0];
                    r_state <= B_VOLT;
                end
                B_VOLT: begin
                    r_prod  <= w_prod;
                    r_state <= B_VSET;
                end
                B_VSET: begin
                    r_v     <= r_prod[ADC_BITS +: asdl_pkg::V_W];
                    r_acc   <= $signed(i_cfg.coef[asdl_pkg::REG_COEF_POW6[asdl_pkg::K_W-1:0]]);
                    r_k     <= asdl_pkg::REG_COEF_POW5[asdl_pkg::K_W-1:0];
                    r_state <= B_HMUL;
                end
                B_HMUL: begin
                    r_prod  <= w_prod;
                    r_state <= B_HADD;
                end
                B_HADD: begin
                    r_acc <= $signed(w_hsat);
                    if (r_k == asdl_pkg::REG_COEF_CONST[asdl_pkg::K_W-1:0]) begin
                        r_state <= B_OUT;
                    end else begin
                        r_k     <= r_k + asdl_pkg::K_W'(1);
                        r_state <= B_HMUL;
                    end
                end
                B_OUT: begin
                    if (!i_res_full) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule
